// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/lesf_pkg.sv =====
package lesf_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int POS_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 11;

    localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'd46;

    typedef struct packed {
        logic             valid;
        logic             empty;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last_col;
        logic             last;
    } item_t;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } rd_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [SIDE_W-1:0] data;
    } wr_t;

endpackage

// ===== rtl/core/lesf_row_ram.sv =====
module lesf_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/lesf_scan_ctrl.sv =====
`include "assert_macros.svh"

module lesf_scan_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr,
    input  logic [lesf_pkg::CFG_W-1:0]  grid_side,
    input  logic                        cell_valid,
    input  logic [lesf_pkg::CHAR_W-1:0] cell_char,
    input  logic                        out_busy,
    output logic                        cell_stall,
    output lesf_pkg::item_t             item,
    output lesf_pkg::rd_t               rd
);

    logic [lesf_pkg::POS_W-1:0] side_m1_reg, side_m1_next;
    logic [lesf_pkg::POS_W-1:0] row_reg, row_next;
    logic [lesf_pkg::POS_W-1:0] col_reg, col_next;
    lesf_pkg::item_t            item_reg, item_next;
    logic                       is_last_col;
    logic                       is_last;
    logic                       accept;
    logic [lesf_pkg::CFG_W-1:0] side_eff;

    // clamp the written side to 1..MAX_SIDE
    always_comb
    begin
        if (grid_side == '0)
        begin
            side_eff = lesf_pkg::CFG_W'(1);
        end
        else if (grid_side > lesf_pkg::CFG_W'(lesf_pkg::MAX_SIDE))
        begin
            side_eff = lesf_pkg::CFG_W'(lesf_pkg::MAX_SIDE);
        end
        else
        begin
            side_eff = grid_side;
        end
    end

    assign is_last_col = (col_reg == side_m1_reg);
    assign is_last     = is_last_col && (row_reg == side_m1_reg);

    // a grid-ending word waits until the result path has room
    assign cell_stall = is_last && out_busy;
    assign accept     = cell_valid && !cell_stall;

    always_comb
    begin
        side_m1_next = side_m1_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        if (cfg_wr)
        begin
            side_m1_next = lesf_pkg::POS_W'(side_eff - lesf_pkg::CFG_W'(1));
            row_next     = '0;
            col_next     = '0;
        end
        else if (accept)
        begin
            if (is_last_col)
            begin
                col_next = '0;
                row_next = is_last ? '0 : row_reg + lesf_pkg::POS_W'(1);
            end
            else
            begin
                col_next = col_reg + lesf_pkg::POS_W'(1);
            end
        end
    end

    always_comb
    begin
        item_next          = item_reg;
        item_next.valid    = accept;
        if (accept)
        begin
            item_next.empty    = (cell_char == lesf_pkg::EMPTY_CHAR);
            item_next.row      = row_reg;
            item_next.col      = col_reg;
            item_next.last_col = is_last_col;
            item_next.last     = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_m1_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            item_reg    <= '0;
        end
        else
        begin
            side_m1_reg <= side_m1_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            item_reg    <= item_next;
        end
    end

    assign item    = item_reg;
    assign rd.en   = accept;
    assign rd.addr = col_reg;

    `ASSERT_NEXT(a_col_step, clk, rst_n, accept && !is_last_col && !cfg_wr,
        col_reg == $past(col_reg) + lesf_pkg::POS_W'(1), "column did not advance")
    `ASSERT_NEXT(a_last_flag, clk, rst_n, accept && is_last && !cfg_wr,
        item_reg.last && row_reg == '0 && col_reg == '0, "grid end not flagged")

endmodule

// ===== rtl/core/lesf_dp_stage.sv =====
`include "assert_macros.svh"

module lesf_dp_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr,
    input  lesf_pkg::item_t             item,
    input  lesf_pkg::rd_t               rd,
    input  logic [lesf_pkg::SIDE_W-1:0] rdata,
    input  logic                        result_stall,
    output lesf_pkg::wr_t               wr,
    output logic                        out_busy,
    output logic                        result_valid,
    output logic [lesf_pkg::SIDE_W-1:0] square_size,
    output logic [lesf_pkg::POS_W-1:0]  top_row,
    output logic [lesf_pkg::POS_W-1:0]  left_col
);

    logic                        fwd_hit_reg, fwd_hit_next;
    logic [lesf_pkg::SIDE_W-1:0] fwd_data_reg;
    logic [lesf_pkg::SIDE_W-1:0] left_reg, left_next;
    logic [lesf_pkg::SIDE_W-1:0] diag_reg, diag_next;
    logic [lesf_pkg::SIDE_W-1:0] best_size_reg, best_size_next;
    logic [lesf_pkg::POS_W-1:0]  best_row_reg, best_row_next;
    logic [lesf_pkg::POS_W-1:0]  best_col_reg, best_col_next;
    logic                        out_valid_reg, out_valid_next;
    logic [lesf_pkg::SIDE_W-1:0] out_size_reg;
    logic [lesf_pkg::POS_W-1:0]  out_row_reg;
    logic [lesf_pkg::POS_W-1:0]  out_col_reg;
    logic                        skid_valid_reg, skid_valid_next;
    logic [lesf_pkg::SIDE_W-1:0] skid_size_reg;
    logic [lesf_pkg::POS_W-1:0]  skid_row_reg;
    logic [lesf_pkg::POS_W-1:0]  skid_col_reg;
    logic                        pop;
    logic                        load_out_new;
    logic                        load_out_skid;
    logic                        load_skid;
    logic [lesf_pkg::SIDE_W-1:0] up;
    logic [lesf_pkg::SIDE_W-1:0] left;
    logic [lesf_pkg::SIDE_W-1:0] diag;
    logic [lesf_pkg::SIDE_W-1:0] m01;
    logic [lesf_pkg::SIDE_W-1:0] mmin;
    logic [lesf_pkg::SIDE_W-1:0] v;
    logic [lesf_pkg::SIDE_W-1:0] row_top;
    logic [lesf_pkg::SIDE_W-1:0] col_top;
    logic                        emit;

    // store entry written on the same edge as the read is taken from the bypass
    always_comb
    begin
        if (item.row == '0)
        begin
            up = '0;
        end
        else
        begin
            up = fwd_hit_reg ? fwd_data_reg : rdata;
        end
    end

    assign left = (item.col != '0) ? left_reg : '0;
    assign diag = (item.col != '0 && item.row != '0) ? diag_reg : '0;
    assign m01  = (up < left) ? up : left;
    assign mmin = (m01 < diag) ? m01 : diag;
    assign v    = item.empty ? mmin + lesf_pkg::SIDE_W'(1) : '0;

    assign row_top = {1'b0, item.row} + lesf_pkg::SIDE_W'(1) - v;
    assign col_top = {1'b0, item.col} + lesf_pkg::SIDE_W'(1) - v;

    assign wr.en   = item.valid;
    assign wr.addr = item.col;
    assign wr.data = v;

    assign fwd_hit_next = rd.en ? (wr.en && wr.addr == rd.addr) : fwd_hit_reg;
    assign emit         = item.valid && item.last;

    always_comb
    begin
        left_next      = left_reg;
        diag_next      = diag_reg;
        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (item.valid)
        begin
            left_next = v;
            diag_next = up;
            if (v > best_size_reg)
            begin
                best_size_next = v;
                best_row_next  = row_top[lesf_pkg::POS_W-1:0];
                best_col_next  = col_top[lesf_pkg::POS_W-1:0];
            end
        end
        if (cfg_wr || (item.valid && item.last_col))
        begin
            left_next = '0;
            diag_next = '0;
        end
    end

    // two-word result buffer: head word on the ports, spare word behind it
    assign pop = out_valid_reg && !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_new    = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                load_out_skid   = 1'b1;
                skid_valid_next = emit;
                load_skid       = emit;
            end
            else
            begin
                out_valid_next = emit;
                load_out_new   = emit;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg)
            begin
                skid_valid_next = 1'b1;
                load_skid       = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
                load_out_new   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg    <= 1'b0;
            left_reg       <= '0;
            diag_reg       <= '0;
            best_size_reg  <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg    <= fwd_hit_next;
            left_reg       <= left_next;
            diag_reg       <= diag_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_wr || emit)
            begin
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else
            begin
                best_size_reg <= best_size_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            fwd_data_reg <= v;
        end
        if (load_out_skid)
        begin
            out_size_reg <= skid_size_reg;
            out_row_reg  <= skid_row_reg;
            out_col_reg  <= skid_col_reg;
        end
        else if (load_out_new)
        begin
            out_size_reg <= best_size_next;
            out_row_reg  <= best_row_next;
            out_col_reg  <= best_col_next;
        end
        if (load_skid)
        begin
            skid_size_reg <= best_size_next;
            skid_row_reg  <= best_row_next;
            skid_col_reg  <= best_col_next;
        end
    end

    // full after this edge: a grid end taken now could not be stored
    assign out_busy     = skid_valid_next;
    assign result_valid = out_valid_reg;
    assign square_size  = out_size_reg;
    assign top_row      = out_row_reg;
    assign left_col     = out_col_reg;

    `ASSERT_IMPL(a_no_overrun, clk, rst_n, emit, !(skid_valid_reg && result_stall),
        "result overwritten while waiting")
    `ASSERT_IMPL(a_new_word_src, clk, rst_n, out_valid_reg && !$past(out_valid_reg),
        $past(emit), "result word without a grid end")
    `ASSERT_IMPL(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg,
        "spare result without a head word")
    `ASSERT_IMPL(a_size_fits, clk, rst_n, item.valid,
        v <= {1'b0, item.row} + lesf_pkg::SIDE_W'(1)
        && v <= {1'b0, item.col} + lesf_pkg::SIDE_W'(1), "square exceeds its corner")

endmodule

// ===== rtl/core/largest_empty_square_finder.sv =====
// Finds the largest all-empty square in a square grid streamed in row-major order,
// one cell byte per word ('.' is empty). Write grid_side (clamped to 1..1024) while
// idle; a write restarts the scan. One result word follows each grid's last cell,
// registered in the item register and then the result buffer, giving the side and
// top-left corner; ties go to the first corner in row-major order, and a grid with no
// empty cell reports all zeros. Cells are taken one per cycle through a two-stage
// read-modify-write of the one-row side store; results queue in a two-word buffer and
// the last cell of a grid is held off only while that buffer would be full, so cells
// keep one per cycle, even for 1x1 grids, whenever results are taken at once.
module largest_empty_square_finder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lesf_pkg::CFG_W-1:0]  grid_side,
    input  logic                        cell_valid,
    output logic                        cell_stall,
    input  logic [lesf_pkg::CHAR_W-1:0] cell_char,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [lesf_pkg::SIDE_W-1:0] square_size,
    output logic [lesf_pkg::POS_W-1:0]  top_row,
    output logic [lesf_pkg::POS_W-1:0]  left_col
);

    lesf_pkg::item_t             item;
    lesf_pkg::rd_t               rd;
    lesf_pkg::wr_t               wr;
    logic [lesf_pkg::SIDE_W-1:0] rdata;
    logic                        out_busy;
    logic                        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    lesf_scan_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .grid_side  (grid_side),
        .cell_valid (cell_valid),
        .cell_char  (cell_char),
        .out_busy   (out_busy),
        .cell_stall (cell_stall),
        .item       (item),
        .rd         (rd)
    );

    lesf_row_ram #(
        .DEPTH (lesf_pkg::MAX_SIDE),
        .WIDTH (lesf_pkg::SIDE_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (rdata)
    );

    lesf_dp_stage u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .item         (item),
        .rd           (rd),
        .rdata        (rdata),
        .result_stall (result_stall),
        .wr           (wr),
        .out_busy     (out_busy),
        .result_valid (result_valid),
        .square_size  (square_size),
        .top_row      (top_row),
        .left_col     (left_col)
    );

endmodule
